@@ sv/lhs_pkg.sv @@
`default_nettype none

package lhs_pkg;

    localparam int unsigned LHS_AGE_W   = 16;
    localparam int unsigned LHS_VER_W   = 8;
    localparam int unsigned LHS_CFG_W   = 16;
    localparam int unsigned LHS_IDX_W   = 3;
    localparam int unsigned LHS_RETRY_W = 2;

    localparam logic [LHS_AGE_W-1:0]   LHS_AGE_MAX     = '1;
    localparam logic [LHS_RETRY_W-1:0] LHS_MAX_RETRIES = 2'd3;

    localparam logic [LHS_AGE_W-1:0] LHS_RST_PING_INTERVAL     = 16'd1000;
    localparam logic [LHS_AGE_W-1:0] LHS_RST_REPLY_TIMEOUT     = 16'd3000;
    localparam logic [LHS_AGE_W-1:0] LHS_RST_HANDSHAKE_TIMEOUT = 16'd500;
    localparam logic [LHS_VER_W-1:0] LHS_RST_EXPECTED_MAJOR    = 8'd1;
    localparam logic [LHS_VER_W-1:0] LHS_RST_EXPECTED_MINOR    = 8'd0;

    typedef enum logic [1:0] {
        PH_ONLINE       = 2'd0,
        PH_WAIT_PING    = 2'd1,
        PH_WAIT_VERSION = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_PING_REPLY = 3'd1,
        KIND_CAPS_REPLY = 3'd2,
        KIND_VER_REPLY  = 3'd3,
        KIND_REBOOT     = 3'd4
    } t_kind;

    typedef enum logic [LHS_IDX_W-1:0] {
        CFG_PING_INTERVAL     = 3'd0,
        CFG_REPLY_TIMEOUT     = 3'd1,
        CFG_HANDSHAKE_TIMEOUT = 3'd2,
        CFG_EXPECTED_MAJOR    = 3'd3,
        CFG_EXPECTED_MINOR    = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [2:0]           kind;
        logic                 link_open;
        logic                 major_present;
        logic [LHS_VER_W-1:0] major_number;
        logic                 minor_present;
        logic [LHS_VER_W-1:0] minor_number;
    } t_lhs_in;

    typedef struct packed {
        logic       send_ping;
        logic       send_version_query;
        logic       send_caps_query;
        logic [1:0] phase;
        logic       partner_online;
        logic       heartbeat_lost;
        logic       heartbeat_timeout;
        logic       version_mismatch;
    } t_lhs_out;

    typedef struct packed {
        logic [LHS_AGE_W-1:0] ping_interval_ms;
        logic [LHS_AGE_W-1:0] reply_timeout_ms;
        logic [LHS_AGE_W-1:0] hs_timeout_ms;
        logic [LHS_VER_W-1:0] expected_major;
        logic [LHS_VER_W-1:0] expected_minor;
    } t_lhs_cfg;

    typedef struct packed {
        t_phase                 link_phase;
        logic                   online_flag;
        logic                   lost_flag;
        logic [LHS_AGE_W-1:0]   ping_age;
        logic [LHS_AGE_W-1:0]   reply_age;
        logic [LHS_AGE_W-1:0]   phase_age;
        logic [LHS_RETRY_W-1:0] retry_count;
    } t_lhs_state;

    function automatic logic [LHS_AGE_W-1:0] age_up(input logic [LHS_AGE_W-1:0] a);
        age_up = (a == LHS_AGE_MAX) ? a : a + 1'b1;
    endfunction

endpackage

`default_nettype wire

@@ sv/link_handshake_supervisor.sv @@
// Output: the result of an accepted transfer is registered and drives the output.
// Throughput: one item per cycle; the next item is taken while a result waits, as long as
// the result register is empty or is being taken in the same cycle.
// Reset (synchronous, active low): wait ping, offline, heartbeat lost, ages and retry count
// cleared, registers at their defaults, no result pending.
`default_nettype none

module link_handshake_supervisor
    import lhs_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire t_lhs_in         i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output t_lhs_out             o_out_data,
    input  wire                  i_cfg_we,
    input  wire [LHS_IDX_W-1:0]  i_cfg_index,
    input  wire [LHS_CFG_W-1:0]  i_cfg_data
);

    t_lhs_cfg   r_cfg;
    t_lhs_state r_state;
    t_lhs_state n_state;
    t_lhs_out   n_result;
    t_lhs_out   r_result;
    logic       r_out_valid;
    logic       w_accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_result;

    lhs_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ping_interval_ms <= LHS_RST_PING_INTERVAL;
            r_cfg.reply_timeout_ms <= LHS_RST_REPLY_TIMEOUT;
            r_cfg.hs_timeout_ms    <= LHS_RST_HANDSHAKE_TIMEOUT;
            r_cfg.expected_major   <= LHS_RST_EXPECTED_MAJOR;
            r_cfg.expected_minor   <= LHS_RST_EXPECTED_MINOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PING_INTERVAL:     r_cfg.ping_interval_ms <= i_cfg_data;
                CFG_REPLY_TIMEOUT:     r_cfg.reply_timeout_ms <= i_cfg_data;
                CFG_HANDSHAKE_TIMEOUT: r_cfg.hs_timeout_ms    <= i_cfg_data;
                CFG_EXPECTED_MAJOR:    r_cfg.expected_major   <= i_cfg_data[LHS_VER_W-1:0];
                CFG_EXPECTED_MINOR:    r_cfg.expected_minor   <= i_cfg_data[LHS_VER_W-1:0];
                default:               r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.link_phase  <= PH_WAIT_PING;
            r_state.online_flag <= 1'b0;
            r_state.lost_flag   <= 1'b1;
            r_state.ping_age    <= '0;
            r_state.reply_age   <= '0;
            r_state.phase_age   <= '0;
            r_state.retry_count <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

@@ sv/lhs_step.sv @@
`default_nettype none

module lhs_step
    import lhs_pkg::*;
(
    input  wire t_lhs_state i_state,
    input  wire t_lhs_cfg   i_cfg,
    input  wire t_lhs_in    i_item,
    output t_lhs_state      o_state,
    output t_lhs_out        o_result
);

    logic [LHS_AGE_W-1:0] w_ping_age_up;
    logic [LHS_AGE_W-1:0] w_reply_age_up;
    logic [LHS_AGE_W-1:0] w_phase_age_up;
    logic                 w_ping_due;
    logic                 w_hb_due;
    logic                 w_hs_due;
    logic                 w_retry_left;
    logic                 w_match;

    assign w_ping_age_up  = age_up(i_state.ping_age);
    assign w_reply_age_up = age_up(i_state.reply_age);
    assign w_phase_age_up = age_up(i_state.phase_age);
    assign w_ping_due     = w_ping_age_up >= i_cfg.ping_interval_ms;
    assign w_hb_due       = (w_reply_age_up > i_cfg.reply_timeout_ms) && i_item.link_open
                            && i_state.online_flag;
    assign w_hs_due       = i_item.link_open && !w_hb_due
                            && (i_state.link_phase == PH_WAIT_VERSION)
                            && (w_phase_age_up >= i_cfg.hs_timeout_ms);
    assign w_retry_left   = i_state.retry_count != LHS_MAX_RETRIES;
    assign w_match        = i_item.major_present && i_item.minor_present
                            && (i_item.major_number == i_cfg.expected_major)
                            && (i_item.minor_number == i_cfg.expected_minor);

    // next state
    always_comb begin
        o_state = i_state;
        unique case (i_item.kind)
            KIND_TICK: begin
                o_state.ping_age  = w_ping_age_up;
                o_state.reply_age = w_reply_age_up;
                o_state.phase_age = w_phase_age_up;
                if (!i_item.link_open) begin
                    o_state.online_flag = 1'b0;
                    o_state.link_phase  = PH_WAIT_PING;
                    o_state.lost_flag   = 1'b1;
                    o_state.retry_count = '0;
                end
                if (w_ping_due) begin
                    o_state.ping_age = '0;
                end
                if (w_hb_due) begin
                    o_state.online_flag = 1'b0;
                    o_state.lost_flag   = 1'b1;
                    o_state.link_phase  = PH_WAIT_PING;
                    o_state.phase_age   = '0;
                    o_state.retry_count = '0;
                end
                if (w_hs_due) begin
                    if (w_retry_left) begin
                        o_state.retry_count = i_state.retry_count + 1'b1;
                    end else begin
                        o_state.retry_count = '0;
                        o_state.link_phase  = PH_WAIT_PING;
                        o_state.online_flag = 1'b0;
                    end
                    o_state.phase_age = '0;
                end
            end
            KIND_PING_REPLY: begin
                o_state.reply_age = '0;
                if (i_state.link_phase == PH_WAIT_PING) begin
                    o_state.link_phase = PH_WAIT_VERSION;
                    o_state.phase_age  = '0;
                end else if (i_state.link_phase == PH_ONLINE) begin
                    o_state.lost_flag   = 1'b0;
                    o_state.online_flag = 1'b1;
                end
            end
            KIND_CAPS_REPLY: begin
                if (i_state.link_phase == PH_WAIT_VERSION) begin
                    o_state.online_flag = 1'b1;
                    o_state.link_phase  = PH_ONLINE;
                    o_state.lost_flag   = 1'b0;
                    o_state.retry_count = '0;
                end
            end
            KIND_VER_REPLY: begin
                if (i_state.link_phase == PH_WAIT_VERSION) begin
                    if (w_match) begin
                        o_state.phase_age = '0;
                    end
                end else if (w_match) begin
                    o_state.online_flag = 1'b1;
                    o_state.reply_age   = '0;
                end
            end
            KIND_REBOOT: begin
                o_state.online_flag = 1'b0;
                o_state.link_phase  = PH_WAIT_PING;
                o_state.lost_flag   = 1'b1;
                o_state.ping_age    = '0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    // result flags
    always_comb begin
        o_result                    = '0;
        o_result.phase              = o_state.link_phase;
        o_result.partner_online     = o_state.online_flag;
        o_result.heartbeat_lost     = o_state.lost_flag;
        unique case (i_item.kind)
            KIND_TICK: begin
                o_result.send_ping          = w_ping_due && i_item.link_open;
                o_result.heartbeat_timeout  = w_hb_due;
                o_result.send_version_query = w_hs_due && w_retry_left;
            end
            KIND_PING_REPLY: begin
                o_result.send_version_query = i_state.link_phase == PH_WAIT_PING;
            end
            KIND_CAPS_REPLY: begin
                o_result.send_caps_query = 1'b0;
            end
            KIND_VER_REPLY: begin
                if (i_state.link_phase == PH_WAIT_VERSION) begin
                    o_result.send_caps_query  = w_match;
                    o_result.version_mismatch = !w_match && i_item.major_present;
                end
            end
            KIND_REBOOT: begin
                o_result.send_ping = 1'b1;
            end
            default: begin
                o_result.send_ping = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ tb/tb_link_handshake_supervisor.sv @@
module tb_link_handshake_supervisor;
    timeunit 1ns;
    timeprecision 1ps;

    import lhs_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_lhs_in              in_data;
    logic                 out_valid;
    logic                 out_ready;
    t_lhs_out             out_data;
    logic                 cfg_we;
    logic [LHS_IDX_W-1:0] cfg_index;
    logic [LHS_CFG_W-1:0] cfg_data;

    t_lhs_cfg               model_cfg;
    t_phase                 mdl_phase;
    logic                   mdl_online;
    logic                   mdl_lost;
    logic [LHS_AGE_W-1:0]   ping_age;
    logic [LHS_AGE_W-1:0]   reply_age;
    logic [LHS_AGE_W-1:0]   phase_age;
    logic [LHS_RETRY_W-1:0] hs_retries;

    t_lhs_out    status_queue[$];
    t_lhs_out    oldest;
    int unsigned mismatch_count;
    int unsigned events_sent;
    bit          idling_on;
    bit          tx_gaps;
    bit          rx_gaps;
    int unsigned rx_hold;
    int unsigned rx_stall;

    link_handshake_supervisor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [LHS_AGE_W-1:0] older(input logic [LHS_AGE_W-1:0] a);
        return (&a) ? a : a + 16'd1;
    endfunction

    function automatic t_lhs_out predict_status(input t_lhs_in ev);
        t_lhs_out r;
        logic     ver_ok;
        r = '0;
        ver_ok = ev.major_present && ev.major_number == model_cfg.expected_major &&
                 ev.minor_present && ev.minor_number == model_cfg.expected_minor;
        case (ev.kind)
            KIND_TICK: begin
                ping_age  = older(ping_age);
                reply_age = older(reply_age);
                phase_age = older(phase_age);
                if (!ev.link_open) begin
                    mdl_online = 1'b0;
                    mdl_phase  = PH_WAIT_PING;
                    mdl_lost   = 1'b1;
                    hs_retries = '0;
                end
                if (ping_age >= model_cfg.ping_interval_ms) begin
                    r.send_ping = ev.link_open;
                    ping_age    = '0;
                end
                if (reply_age > model_cfg.reply_timeout_ms && mdl_online) begin
                    mdl_online          = 1'b0;
                    mdl_lost            = 1'b1;
                    mdl_phase           = PH_WAIT_PING;
                    phase_age           = '0;
                    hs_retries          = '0;
                    r.heartbeat_timeout = 1'b1;
                end
                if (mdl_phase == PH_WAIT_VERSION &&
                    phase_age >= model_cfg.hs_timeout_ms) begin
                    if (hs_retries < LHS_MAX_RETRIES) begin
                        hs_retries           = hs_retries + 1'b1;
                        r.send_version_query = 1'b1;
                    end else begin
                        hs_retries = '0;
                        mdl_phase  = PH_WAIT_PING;
                        mdl_online = 1'b0;
                    end
                    phase_age = '0;
                end
            end
            KIND_PING_REPLY: begin
                reply_age = '0;
                if (mdl_phase == PH_WAIT_PING) begin
                    r.send_version_query = 1'b1;
                    mdl_phase            = PH_WAIT_VERSION;
                    phase_age            = '0;
                end else if (mdl_phase == PH_ONLINE) begin
                    mdl_lost   = 1'b0;
                    mdl_online = 1'b1;
                end
            end
            KIND_CAPS_REPLY: begin
                if (mdl_phase == PH_WAIT_VERSION) begin
                    mdl_online = 1'b1;
                    mdl_phase  = PH_ONLINE;
                    mdl_lost   = 1'b0;
                    hs_retries = '0;
                end
            end
            KIND_VER_REPLY: begin
                if (mdl_phase == PH_WAIT_VERSION) begin
                    if (ver_ok) begin
                        r.send_caps_query = 1'b1;
                        phase_age         = '0;
                    end else if (ev.major_present) begin
                        r.version_mismatch = 1'b1;
                    end
                end else if (ver_ok) begin
                    mdl_online = 1'b1;
                    reply_age  = '0;
                end
            end
            KIND_REBOOT: begin
                mdl_online  = 1'b0;
                mdl_phase   = PH_WAIT_PING;
                mdl_lost    = 1'b1;
                r.send_ping = 1'b1;
                ping_age    = '0;
            end
            default: ;
        endcase
        r.phase          = mdl_phase;
        r.partner_online = mdl_online;
        r.heartbeat_lost = mdl_lost;
        return r;
    endfunction

    function automatic t_lhs_in noise_event();
        logic [31:0] raw;
        raw = $urandom;
        return t_lhs_in'(raw[$bits(t_lhs_in)-1:0]);
    endfunction

    function automatic t_lhs_in make_event(input t_kind k);
        t_lhs_in ev;
        ev      = noise_event();
        ev.kind = k;
        return ev;
    endfunction

    function automatic t_lhs_in make_tick(input logic open);
        t_lhs_in ev;
        ev           = make_event(KIND_TICK);
        ev.link_open = open;
        return ev;
    endfunction

    function automatic t_lhs_in make_version(input logic mp, input logic [7:0] maj,
                                             input logic np, input logic [7:0] mnr);
        t_lhs_in ev;
        ev               = make_event(KIND_VER_REPLY);
        ev.major_present = mp;
        ev.major_number  = maj;
        ev.minor_present = np;
        ev.minor_number  = mnr;
        return ev;
    endfunction

    function automatic t_lhs_in good_version();
        return make_version(1'b1, model_cfg.expected_major, 1'b1, model_cfg.expected_minor);
    endfunction

    task automatic send_event(input t_lhs_in ev);
        t_lhs_out want;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 13)) @(negedge clk) in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (!in_ready);
        want = predict_status(ev);
        status_queue.push_back(want);
        if (ev.kind <= KIND_REBOOT) events_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (status_queue.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [LHS_CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_PING_INTERVAL:     model_cfg.ping_interval_ms = val;
            CFG_REPLY_TIMEOUT:     model_cfg.reply_timeout_ms = val;
            CFG_HANDSHAKE_TIMEOUT: model_cfg.hs_timeout_ms    = val;
            CFG_EXPECTED_MAJOR:    model_cfg.expected_major   = val[LHS_VER_W-1:0];
            CFG_EXPECTED_MINOR:    model_cfg.expected_minor   = val[LHS_VER_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] ping, input logic [15:0] reply,
                             input logic [15:0] hs, input logic [7:0] maj,
                             input logic [7:0] mnr);
        logic [7:0] junk;
        write_reg(CFG_PING_INTERVAL, ping);
        write_reg(CFG_REPLY_TIMEOUT, reply);
        write_reg(CFG_HANDSHAKE_TIMEOUT, hs);
        junk = 8'($urandom);
        write_reg(CFG_EXPECTED_MAJOR, {junk, maj});
        junk = 8'($urandom);
        write_reg(CFG_EXPECTED_MINOR, {junk, mnr});
    endtask

    task automatic write_random_config();
        write_all(16'($urandom_range(1, 15)), 16'($urandom_range(1, 40)),
                  16'($urandom_range(1, 12)), 8'($urandom), 8'($urandom));
    endtask

    // one handshake attempt followed by a stretch of link activity
    task automatic run_session();
        t_lhs_in     ev;
        int unsigned pick;
        if ($urandom_range(0, 3) != 0) send_event(make_event(KIND_PING_REPLY));
        repeat ($urandom_range(0, 6)) send_event(make_tick($urandom_range(0, 29) != 0));
        case ($urandom_range(0, 5))
            0: send_event(make_event(KIND_VER_REPLY));
            1: begin
                ev = make_event(KIND_VER_REPLY);
                ev.major_present = 1'b1;
                send_event(ev);
            end
            default: send_event(good_version());
        endcase
        if ($urandom_range(0, 4) != 0) send_event(make_event(KIND_CAPS_REPLY));
        repeat ($urandom_range(1, 40)) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)      send_event(make_tick($urandom_range(0, 29) != 0));
            else if (pick < 92) send_event(make_event(KIND_PING_REPLY));
            else if (pick < 96) send_event(good_version());
            else if (pick < 98) send_event(make_event(KIND_REBOOT));
            else                send_event(noise_event());
        end
    endtask

    task automatic random_phase(input int unsigned quota);
        int unsigned target;
        target = events_sent + quota;
        while (events_sent < target) begin
            tx_gaps = idling_on && $urandom_range(0, 9) < 7;
            rx_gaps = idling_on && $urandom_range(0, 9) < 7;
            if ($urandom_range(0, 9) < 7) run_session();
            else send_event(noise_event());
        end
    endtask

    task automatic test_directed();
        t_lhs_in ev;
        write_all(16'd2, 16'd3, 16'd1, 8'hFF, 8'h00);
        send_event(make_tick(1'b1));
        send_event(make_tick(1'b0));
        send_event(make_event(KIND_PING_REPLY));
        send_event(make_version(1'b0, 8'hFF, 1'b1, 8'h00));
        send_event(make_version(1'b1, 8'hFF, 1'b1, 8'h01));
        send_event(make_version(1'b1, 8'hFF, 1'b0, 8'h00));
        send_event(make_version(1'b1, 8'hFF, 1'b1, 8'h00));
        // exhaust the version query retries
        repeat (4) send_event(make_tick(1'b1));
        send_event(make_event(KIND_PING_REPLY));
        send_event(make_event(KIND_CAPS_REPLY));
        send_event(make_event(KIND_PING_REPLY));
        send_event(make_version(1'b1, 8'hFF, 1'b1, 8'h00));
        send_event(make_version(1'b1, 8'h00, 1'b1, 8'h00));
        send_event(make_event(KIND_CAPS_REPLY));
        repeat (4) send_event(make_tick(1'b1));
        send_event(make_event(KIND_REBOOT));
        for (int k = KIND_REBOOT + 1; k < 8; k++) begin
            ev      = make_event(KIND_TICK);
            ev.kind = k[2:0];
            send_event(ev);
        end
        settle();
        write_all(16'd0, 16'd0, 16'd0, 8'h00, 8'hFF);
        send_event(make_event(KIND_PING_REPLY));
        send_event(make_tick(1'b1));
        send_event(make_version(1'b1, 8'h00, 1'b1, 8'hFF));
        send_event(make_event(KIND_CAPS_REPLY));
        send_event(make_tick(1'b1));
        settle();
    endtask

    task automatic test_backpressure();
        write_random_config();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        rx_hold = 300;
        repeat (3) run_session();
        settle();
    endtask

    task automatic test_random_traffic();
        idling_on = 1'b1;
        write_all(16'd1, 16'd1, 16'd1, 8'h00, 8'hFF);
        random_phase(250);
        settle();
        write_all(16'hFFFF, 16'd1, 16'hFFFF, 8'hFF, 8'h00);
        random_phase(150);
        for (int p = 0; p < 3; p++) begin
            settle();
            write_random_config();
            random_phase(220);
        end
        settle();
        idling_on = 1'b0;
        tx_gaps   = 1'b0;
        rx_gaps   = 1'b0;
    endtask

    // hold the link online under the widest timeouts, then drop the reply timeout
    task automatic test_age_saturation();
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00);
        send_event(make_event(KIND_PING_REPLY));
        send_event(good_version());
        send_event(make_event(KIND_CAPS_REPLY));
        repeat (40) send_event(make_tick(1'b1));
        settle();
        write_reg(CFG_REPLY_TIMEOUT, 16'd20);
        send_event(make_tick(1'b1));
        send_event(make_tick(1'b1));
        settle();
    endtask

    task automatic test_quiet_finish();
        write_random_config();
        random_phase(150);
        settle();
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(negedge clk) begin
        if (rx_hold != 0) begin
            out_ready <= 1'b0;
            rx_hold--;
        end else if (rx_stall != 0) begin
            out_ready <= 1'b0;
            rx_stall--;
        end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            rx_stall = $urandom_range(0, 12);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (status_queue.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transfer, expected none actual %p", $time, out_data);
            end else begin
                oldest = status_queue.pop_front();
                compare_field("send_ping", oldest.send_ping, out_data.send_ping);
                compare_field("send_version_query", oldest.send_version_query,
                              out_data.send_version_query);
                compare_field("send_caps_query", oldest.send_caps_query,
                              out_data.send_caps_query);
                compare_field("phase", oldest.phase, out_data.phase);
                compare_field("partner_online", oldest.partner_online,
                              out_data.partner_online);
                compare_field("heartbeat_lost", oldest.heartbeat_lost,
                              out_data.heartbeat_lost);
                compare_field("heartbeat_timeout", oldest.heartbeat_timeout,
                              out_data.heartbeat_timeout);
                compare_field("version_mismatch", oldest.version_mismatch,
                              out_data.version_mismatch);
            end
        end
    end

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        idling_on      = 1'b0;
        tx_gaps        = 1'b0;
        rx_gaps        = 1'b0;
        rx_hold        = 0;
        rx_stall       = 0;
        mismatch_count = 0;
        events_sent    = 0;
        model_cfg.ping_interval_ms = LHS_RST_PING_INTERVAL;
        model_cfg.reply_timeout_ms = LHS_RST_REPLY_TIMEOUT;
        model_cfg.hs_timeout_ms    = LHS_RST_HANDSHAKE_TIMEOUT;
        model_cfg.expected_major   = LHS_RST_EXPECTED_MAJOR;
        model_cfg.expected_minor   = LHS_RST_EXPECTED_MINOR;
        mdl_phase  = PH_WAIT_PING;
        mdl_online = 1'b0;
        mdl_lost   = 1'b1;
        ping_age   = '0;
        reply_age  = '0;
        phase_age  = '0;
        hs_retries = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_traffic();
        test_age_saturation();
        test_quiet_finish();

        repeat (5) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/lhs_pkg.sv
sv/lhs_step.sv
sv/link_handshake_supervisor.sv
tb/tb_link_handshake_supervisor.sv
